// ----- rtl/packet_interval_statistics_top_defines.svh -----
// ----------------------------------------------------------------------------
// Packet interval statistics assertion macros
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKET_INTERVAL_STATISTICS_TOP_DEFINES_SVH
`define PACKET_INTERVAL_STATISTICS_TOP_DEFINES_SVH

// Same-cycle implication.
`define PIS_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pis_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet interval statistics package
// Field widths, register map, reset values and pipeline stage types.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int TS_W   = 32;
  localparam int CH_W   = 8;
  localparam int CNT_W  = 32;
  localparam int ACC_W  = 64;
  localparam int WARM_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_GAP_THRESHOLD = 1'b0;
  localparam logic REG_WARMUP        = 1'b1;

  localparam logic [TS_W-1:0]   GAP_THRESHOLD_RESET = 32'd84000000;
  localparam logic [WARM_W-1:0] WARMUP_RESET        = 16'd1024;

  // Front stage: interval and packet index
  typedef struct packed {
    logic [TS_W-1:0]  interval;
    logic             mm_en;
    logic [CNT_W-1:0] seen;
  } stage_a_t;

  // Square stage
  typedef struct packed {
    logic [TS_W-1:0]  interval;
    logic [ACC_W-1:0] square;
    logic             mm_en;
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] tally;
  } stage_b_t;

  typedef struct packed {
    logic [TS_W-1:0]  interval_ticks;
    logic             gap_flag;
    logic [ACC_W-1:0] interval_sum;
    logic [ACC_W-1:0] interval_sum_squares;
    logic [TS_W-1:0]  interval_min;
    logic [TS_W-1:0]  interval_max;
    logic [CNT_W-1:0] packets_seen;
    logic [CNT_W-1:0] channel_tally;
  } result_t;

endpackage

// ----- rtl/pis_if.sv -----
// ----------------------------------------------------------------------------
// Packet interval statistics channel interfaces
// Valid/ready channels for packet words in and result words out.
// ----------------------------------------------------------------------------
interface pis_in_if;
  logic                      valid;
  logic                      ready;
  logic [pis_pkg::TS_W-1:0]  timestamp;
  logic [pis_pkg::CH_W-1:0]  channel_id;

  modport source (output valid, timestamp, channel_id, input ready);
  modport sink   (input valid, timestamp, channel_id, output ready);
endinterface

interface pis_out_if;
  logic                       valid;
  logic                       ready;
  logic [pis_pkg::TS_W-1:0]   interval_ticks;
  logic                       gap_flag;
  logic [pis_pkg::ACC_W-1:0]  interval_sum;
  logic [pis_pkg::ACC_W-1:0]  interval_sum_squares;
  logic [pis_pkg::TS_W-1:0]   interval_min;
  logic [pis_pkg::TS_W-1:0]   interval_max;
  logic [pis_pkg::CNT_W-1:0]  packets_seen;
  logic [pis_pkg::CNT_W-1:0]  channel_tally;

  modport source (output valid, interval_ticks, gap_flag, interval_sum,
                  interval_sum_squares, interval_min, interval_max,
                  packets_seen, channel_tally, input ready);
  modport sink   (input valid, interval_ticks, gap_flag, interval_sum,
                  interval_sum_squares, interval_min, interval_max,
                  packets_seen, channel_tally, output ready);
endinterface

// ----- rtl/pis_front.sv -----
// ----------------------------------------------------------------------------
// Packet interval statistics front stage
// Unwrap the timestamp into an interval and advance the packet index.
// ----------------------------------------------------------------------------
module pis_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [pis_pkg::TS_W-1:0]      timestamp,
  input  logic [pis_pkg::WARM_W-1:0]    warmup,
  output pis_pkg::stage_a_t             stage_a_r
);

  logic [pis_pkg::TS_W-1:0]  prev_ts_r;
  logic                      seen_first_r;
  logic [pis_pkg::CNT_W-1:0] pkt_idx_r;
  logic [pis_pkg::TS_W-1:0]  interval_nxt;
  logic [pis_pkg::CNT_W-1:0] pkt_idx_nxt;
  logic                      mm_en_nxt;

  // Modular difference covers a single wrap
  assign interval_nxt = seen_first_r ? (timestamp - prev_ts_r) : '0;
  assign pkt_idx_nxt  = (pkt_idx_r == '1) ? pkt_idx_r : pkt_idx_r + pis_pkg::CNT_W'(1);
  assign mm_en_nxt    = pkt_idx_r > pis_pkg::CNT_W'(warmup);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ts_r    <= '0;
      seen_first_r <= 1'b0;
      pkt_idx_r    <= '0;
    end else if (accept) begin
      prev_ts_r    <= timestamp;
      seen_first_r <= 1'b1;
      pkt_idx_r    <= pkt_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_a_r.interval <= interval_nxt;
      stage_a_r.mm_en    <= mm_en_nxt;
      stage_a_r.seen     <= pkt_idx_nxt;
    end
  end

endmodule

// ----- rtl/pis_hist.sv -----
// ----------------------------------------------------------------------------
// Packet interval statistics channel histogram
// Per-channel counters in memory with valid bits; read on accept, write back
// as the word leaves the front stage, forward when the next word hits the same channel.
// ----------------------------------------------------------------------------
module pis_hist #(
  parameter int CHANNELS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         lookup_en,
  input  logic [pis_pkg::CH_W-1:0]     lookup_ch,
  input  logic                         commit_en,
  input  logic [pis_pkg::CH_W-1:0]     commit_ch,
  output logic [pis_pkg::CNT_W-1:0]    tally
);

  localparam int IDX_W = $clog2(CHANNELS);

  logic [pis_pkg::CNT_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]       vld_r;
  logic [pis_pkg::CNT_W-1:0] rd_r;
  logic                      look_ok;
  logic                      commit_ok;
  logic                      wr_en;
  logic [IDX_W-1:0]          look_idx;
  logic [IDX_W-1:0]          commit_idx;

  assign look_ok    = {1'b0, lookup_ch} < (pis_pkg::CH_W+1)'(CHANNELS);
  assign commit_ok  = {1'b0, commit_ch} < (pis_pkg::CH_W+1)'(CHANNELS);
  assign look_idx   = lookup_ch[IDX_W-1:0];
  assign commit_idx = commit_ch[IDX_W-1:0];
  assign wr_en      = commit_en && commit_ok;

  // Saturating increment; out-of-range channels report zero
  assign tally = !commit_ok ? '0 :
                 (rd_r == '1) ? rd_r : rd_r + pis_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[commit_idx] <= tally;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      if (wr_en && (commit_ch == lookup_ch)) begin
        rd_r <= tally;
      end else if (look_ok && vld_r[look_idx]) begin
        rd_r <= mem[look_idx];
      end else begin
        rd_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[commit_idx] <= 1'b1;
    end
  end

endmodule

// ----- rtl/pis_accum.sv -----
// ----------------------------------------------------------------------------
// Packet interval statistics accumulators
// Register the squared interval, then update saturating sums and min/max
// and load the result register.
// ----------------------------------------------------------------------------
module pis_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load_b,
  input  logic                        update,
  input  pis_pkg::stage_a_t           stage_a,
  input  logic [pis_pkg::CNT_W-1:0]   tally,
  input  logic [pis_pkg::TS_W-1:0]    gap_thr,
  output pis_pkg::result_t            res_r
);

  pis_pkg::stage_b_t          stage_b_r;
  logic [pis_pkg::ACC_W-1:0]  sum_r;
  logic [pis_pkg::ACC_W-1:0]  sum_sq_r;
  logic [pis_pkg::TS_W-1:0]   min_r;
  logic [pis_pkg::TS_W-1:0]   max_r;
  logic [pis_pkg::ACC_W:0]    sum_wide;
  logic [pis_pkg::ACC_W:0]    sum_sq_wide;
  logic [pis_pkg::ACC_W-1:0]  sum_nxt;
  logic [pis_pkg::ACC_W-1:0]  sum_sq_nxt;
  logic [pis_pkg::TS_W-1:0]   min_nxt;
  logic [pis_pkg::TS_W-1:0]   max_nxt;

  always_ff @(posedge clk) begin
    if (load_b) begin
      stage_b_r.interval <= stage_a.interval;
      stage_b_r.square   <= pis_pkg::ACC_W'(stage_a.interval) *
                            pis_pkg::ACC_W'(stage_a.interval);
      stage_b_r.mm_en    <= stage_a.mm_en;
      stage_b_r.seen     <= stage_a.seen;
      stage_b_r.tally    <= tally;
    end
  end

  assign sum_wide    = {1'b0, sum_r} + (pis_pkg::ACC_W+1)'(stage_b_r.interval);
  assign sum_sq_wide = {1'b0, sum_sq_r} + {1'b0, stage_b_r.square};
  assign sum_nxt     = sum_wide[pis_pkg::ACC_W] ? '1 : sum_wide[pis_pkg::ACC_W-1:0];
  assign sum_sq_nxt  = sum_sq_wide[pis_pkg::ACC_W] ? '1 :
                       sum_sq_wide[pis_pkg::ACC_W-1:0];
  assign min_nxt     = (stage_b_r.mm_en && (stage_b_r.interval < min_r)) ?
                       stage_b_r.interval : min_r;
  assign max_nxt     = (stage_b_r.mm_en && (stage_b_r.interval > max_r)) ?
                       stage_b_r.interval : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      sum_sq_r <= '0;
      min_r    <= '1;
      max_r    <= '0;
    end else if (update) begin
      sum_r    <= sum_nxt;
      sum_sq_r <= sum_sq_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      res_r.interval_ticks       <= stage_b_r.interval;
      res_r.gap_flag             <= stage_b_r.interval > gap_thr;
      res_r.interval_sum         <= sum_nxt;
      res_r.interval_sum_squares <= sum_sq_nxt;
      res_r.interval_min         <= min_nxt;
      res_r.interval_max         <= max_nxt;
      res_r.packets_seen         <= stage_b_r.seen;
      res_r.channel_tally        <= stage_b_r.tally;
    end
  end

endmodule

// ----- rtl/packet_interval_statistics_top.sv -----
// ----------------------------------------------------------------------------
// Packet interval statistics top level
// Per-packet interval, running sums, min/max and channel histogram, with an
// APB-style register port for the gap threshold and warm-up count.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake          Word
//   in_chan   in   valid/ready        timestamp, channel_id
//   out_chan  out  valid/ready        interval stats, tally
//   cfg_*     in   psel/penable       gap threshold (0x0), warm-up (0x4)
//
// One packet word per cycle is accepted while the output is not stalled; the result
// word passes the front register, square register and result register in turn.
// The histogram read-modify-write spans the first two registers, with a
// forward path for back-to-back words on the same channel.
// Reset is synchronous, active low; in_chan.ready stays low during reset.
// Histogram valid bits clear at once, so no clearing pass is needed.
// A stalled output holds the whole pipeline; in_chan.ready drops with it.
// ----------------------------------------------------------------------------
`include "packet_interval_statistics_top_defines.svh"

module packet_interval_statistics_top #(
  parameter int CHANNELS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pis_in_if.sink                             in_chan,
  pis_out_if.source                          out_chan,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pis_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pis_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pis_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  // Configuration registers
  logic [pis_pkg::TS_W-1:0]   gap_thr_r;
  logic [pis_pkg::WARM_W-1:0] warmup_r;
  logic                       cfg_wr;
  logic                       cfg_sel;

  // Pipeline control
  logic                       advance;
  logic                       accept;
  logic                       a_vld_r;
  logic                       b_vld_r;
  logic                       out_vld_r;
  logic [pis_pkg::CH_W-1:0]   a_ch_r;
  logic [pis_pkg::CNT_W-1:0]  tally;
  pis_pkg::stage_a_t          stage_a_r;
  pis_pkg::result_t           res_r;

  // Register port: always ready, write lands on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_thr_r <= pis_pkg::GAP_THRESHOLD_RESET;
      warmup_r  <= pis_pkg::WARMUP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        pis_pkg::REG_GAP_THRESHOLD: gap_thr_r <= cfg_pwdata;
        pis_pkg::REG_WARMUP:        warmup_r  <= cfg_pwdata[pis_pkg::WARM_W-1:0];
        default:                    gap_thr_r <= gap_thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      pis_pkg::REG_GAP_THRESHOLD: cfg_prdata = gap_thr_r;
      pis_pkg::REG_WARMUP:        cfg_prdata = pis_pkg::CFG_DATA_W'(warmup_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Advance every stage together unless the result word is stuck; hold
  // everything while reset is asserted
  assign advance       = rst_n && (!out_vld_r || out_chan.ready);
  assign accept        = in_chan.valid && advance;
  assign in_chan.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      a_vld_r   <= in_chan.valid;
      b_vld_r   <= a_vld_r;
      out_vld_r <= b_vld_r;
    end
  end

  // Hold the channel alongside the front stage for the histogram write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ch_r <= in_chan.channel_id;
    end
  end

  pis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .timestamp (in_chan.timestamp),
    .warmup    (warmup_r),
    .stage_a_r (stage_a_r)
  );

  pis_hist #(
    .CHANNELS (CHANNELS)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_en (accept),
    .lookup_ch (in_chan.channel_id),
    .commit_en (advance && a_vld_r),
    .commit_ch (a_ch_r),
    .tally     (tally)
  );

  pis_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_b  (advance && a_vld_r),
    .update  (advance && b_vld_r),
    .stage_a (stage_a_r),
    .tally   (tally),
    .gap_thr (gap_thr_r),
    .res_r   (res_r)
  );

  assign out_chan.valid                = out_vld_r;
  assign out_chan.interval_ticks       = res_r.interval_ticks;
  assign out_chan.gap_flag             = res_r.gap_flag;
  assign out_chan.interval_sum         = res_r.interval_sum;
  assign out_chan.interval_sum_squares = res_r.interval_sum_squares;
  assign out_chan.interval_min         = res_r.interval_min;
  assign out_chan.interval_max         = res_r.interval_max;
  assign out_chan.packets_seen         = res_r.packets_seen;
  assign out_chan.channel_tally        = res_r.channel_tally;

  // An accepted word always lands in the front stage
  `PIS_CHECK_NEXT(a_accept_fills_front, accept, a_vld_r,
                  "accepted word lost at front stage")

  // Once min has been set after warm-up, min never exceeds max
  `PIS_CHECK_NOW(a_min_le_max, out_vld_r && (res_r.interval_min != '1),
                 res_r.interval_min <= res_r.interval_max, "interval min above max")

  // One channel never counts more packets than all channels together
  `PIS_CHECK_NOW(a_tally_le_seen, out_vld_r, res_r.channel_tally <= res_r.packets_seen,
                 "channel tally above packet count")

  // The running sum includes the current interval
  `PIS_CHECK_NOW(a_sum_covers_interval, out_vld_r,
                 res_r.interval_sum >= pis_pkg::ACC_W'(res_r.interval_ticks),
                 "interval sum below interval")

endmodule
